FILE: src/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse core.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package m3i_pkg;

    // Port field width and default number format
    localparam int FIELD_W        = 32;
    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SINGULAR  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    // Element numbers (row-major) that form each adjugate entry: a*b - c*d
    localparam int ADJ_IDX [9][4] = '{
        '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] m00;
        logic signed [FIELD_W-1:0] m01;
        logic signed [FIELD_W-1:0] m02;
        logic signed [FIELD_W-1:0] m10;
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m20;
        logic signed [FIELD_W-1:0] m21;
        logic signed [FIELD_W-1:0] m22;
    } m3i_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] inv00;
        logic signed [FIELD_W-1:0] inv01;
        logic signed [FIELD_W-1:0] inv02;
        logic signed [FIELD_W-1:0] inv10;
        logic signed [FIELD_W-1:0] inv11;
        logic signed [FIELD_W-1:0] inv12;
        logic signed [FIELD_W-1:0] inv20;
        logic signed [FIELD_W-1:0] inv21;
        logic signed [FIELD_W-1:0] inv22;
        logic [1:0]                status;
    } m3i_out_t;

    // Per-lane flags handed to the merging stage
    typedef struct packed {
        logic valid;
        logic singular;
        logic sat;
    } m3i_lane_stat_t;

endpackage

FILE: src/m3i_front.sv
// Front end: 18 element products, nine exact adjugate entries, determinant.
// Depends on m3i_pkg (adjugate index table).
`timescale 1ns / 1ps

module m3i_front #(
    parameter int WORD_WIDTH = m3i_pkg::DEF_WORD_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [WORD_WIDTH-1:0] elem [9],
    output logic                         out_valid,
    output logic signed [2*WORD_WIDTH:0] adj [9],
    output logic signed [3*WORD_WIDTH+2:0] det
);
    import m3i_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;

    logic [4:0] valid_reg;

    logic signed [W-1:0]  elem_reg [9];
    logic signed [PW-1:0] prod_p_reg [9];
    logic signed [PW-1:0] prod_q_reg [9];
    logic signed [W-1:0]  row0_s2_reg [3];
    logic signed [W-1:0]  row0_s3_reg [3];
    logic signed [AW-1:0] adj_s3_reg [9];
    logic signed [AW-1:0] adj_s4_reg [9];
    logic signed [AW-1:0] adj_s5_reg [9];
    logic signed [AW-1:0] pp_lo_reg [3];
    logic signed [AW-1:0] pp_hi_reg [3];
    logic signed [DW-1:0] det_next;
    logic signed [DW-1:0] det_reg;

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Capture the word, form the cofactor products
    always_ff @(posedge clk) begin
        for (int i = 0; i < 9; i++) begin
            elem_reg[i] <= elem[i];
        end
        for (int i = 0; i < 3; i++) begin
            row0_s2_reg[i] <= elem_reg[i];
            row0_s3_reg[i] <= row0_s2_reg[i];
        end
    end

    for (genvar g = 0; g < 9; g++) begin : g_cof
        always_ff @(posedge clk) begin
            prod_p_reg[g] <= elem_reg[ADJ_IDX[g][0]] * elem_reg[ADJ_IDX[g][1]];
            prod_q_reg[g] <= elem_reg[ADJ_IDX[g][2]] * elem_reg[ADJ_IDX[g][3]];
            adj_s3_reg[g] <= AW'(prod_p_reg[g]) - AW'(prod_q_reg[g]);
            adj_s4_reg[g] <= adj_s3_reg[g];
            adj_s5_reg[g] <= adj_s4_reg[g];
        end
    end

    // Split each first-column adjugate entry into halves for the determinant
    for (genvar k = 0; k < 3; k++) begin : g_pp
        always_ff @(posedge clk) begin
            pp_lo_reg[k] <= row0_s3_reg[k] * $signed({1'b0, adj_s3_reg[3*k][W-1:0]});
            pp_hi_reg[k] <= row0_s3_reg[k] * $signed(adj_s3_reg[3*k][AW-1:W]);
        end
    end

    // Sum the partial products into the determinant
    always_comb begin
        det_next = '0;
        for (int k = 0; k < 3; k++) begin
            det_next = det_next + (DW'(pp_hi_reg[k]) <<< W) + DW'(pp_lo_reg[k]);
        end
    end

    always_ff @(posedge clk) begin
        det_reg <= det_next;
    end

    assign out_valid = valid_reg[4];
    assign adj       = adj_s5_reg;
    assign det       = det_reg;

endmodule

FILE: src/m3i_lane.sv
// One divider lane: adjugate entry over determinant, one quotient bit a stage,
// with saturation and singular handling. Depends on m3i_pkg.
`timescale 1ns / 1ps

module m3i_lane #(
    parameter int WORD_WIDTH = m3i_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = m3i_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [2*WORD_WIDTH:0]   adj,
    input  logic signed [3*WORD_WIDTH+2:0] det,
    output logic [m3i_pkg::FIELD_W-1:0]    value,
    output m3i_pkg::m3i_lane_stat_t        stat
);
    import m3i_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NW = AW + 2 * FRAC_BITS;
    localparam int CW = (NW > DW + W) ? NW : DW + W;
    localparam int RW = DW;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    // Prep: signs, magnitudes, overflow check
    logic          adj_neg;
    logic          det_neg;
    logic [AW-1:0] adj_mag;
    logic [DW-1:0] det_mag;
    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_ext;

    always_comb begin
        adj_neg = adj[AW-1];
        det_neg = det[DW-1];
        adj_mag = adj_neg ? AW'(-adj) : AW'(adj);
        det_mag = det_neg ? DW'(-det) : DW'(det);
        num_ext = CW'(adj_mag) << (2 * FRAC_BITS);
        den_ext = CW'(det_mag) << W;
    end

    // Division stage registers; entry 0 is the prep stage
    logic          v_reg   [W+1];
    logic          sgn_reg [W+1];
    logic          sing_reg[W+1];
    logic          ovf_reg [W+1];
    logic [DW-1:0] d_reg   [W+1];
    logic [RW-1:0] r_reg   [W+1];
    logic [W-1:0]  nb_reg  [W+1];
    logic [W-1:0]  q_reg   [W+1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg[0] <= 1'b0;
        end else begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        sgn_reg[0]  <= adj_neg ^ det_neg;
        sing_reg[0] <= (det_mag == '0);
        ovf_reg[0]  <= (num_ext >= den_ext);
        d_reg[0]    <= det_mag;
        r_reg[0]    <= RW'(num_ext >> W);
        nb_reg[0]   <= num_ext[W-1:0];
        q_reg[0]    <= '0;
    end

    // One restoring step per stage
    for (genvar j = 0; j < W; j++) begin : g_div
        logic [RW:0]   r_sh;
        logic [RW:0]   r_sub;
        logic          take;

        always_comb begin
            r_sh  = {r_reg[j], nb_reg[j][W-1]};
            r_sub = r_sh - {1'b0, d_reg[j]};
            take  = (r_sh >= {1'b0, d_reg[j]});
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[j+1] <= 1'b0;
            end else begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk) begin
            sgn_reg[j+1]  <= sgn_reg[j];
            sing_reg[j+1] <= sing_reg[j];
            ovf_reg[j+1]  <= ovf_reg[j];
            d_reg[j+1]    <= d_reg[j];
            r_reg[j+1]    <= take ? RW'(r_sub) : RW'(r_sh);
            nb_reg[j+1]   <= {nb_reg[j][W-2:0], 1'b0};
            q_reg[j+1]    <= {q_reg[j][W-2:0], take};
        end
    end

    // Apply sign, clamp out-of-range quotients, zero singular results
    logic          neg;
    logic          sat_next;
    logic [W-1:0]  val_next;
    logic [W-1:0]  qf;
    logic [FIELD_W-1:0] value_reg;
    logic          sat_reg;
    logic          sing_out_reg;
    logic          valid_out_reg;

    always_comb begin
        qf       = q_reg[W];
        neg      = sgn_reg[W] && (ovf_reg[W] || (qf != '0));
        sat_next = 1'b0;
        val_next = '0;
        if (sing_reg[W]) begin
            val_next = '0;
        end else if (ovf_reg[W] || (neg ? (qf > HALF) : qf[W-1])) begin
            sat_next = 1'b1;
            val_next = neg ? HALF : ~HALF;
        end else begin
            val_next = neg ? (~qf + 1'b1) : qf;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_out_reg <= 1'b0;
        end else begin
            valid_out_reg <= v_reg[W];
        end
    end

    always_ff @(posedge clk) begin
        value_reg    <= FIELD_W'($signed(val_next));
        sat_reg      <= sat_next;
        sing_out_reg <= sing_reg[W];
    end

    assign value         = value_reg;
    assign stat.valid    = valid_out_reg;
    assign stat.singular = sing_out_reg;
    assign stat.sat      = sat_reg;

endmodule

FILE: src/matrix3x3_inverse_core.sv
// Top level of the 3x3 fixed-point matrix inverse: front end, nine divider
// lanes and the status merge. Depends on m3i_pkg, m3i_front, m3i_lane.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The lane dividers retire one quotient bit per stage, which sets the depth.
// Reset clears all valid marks; no result is flagged until a new word enters.
`timescale 1ns / 1ps

module matrix3x3_inverse_core #(
    parameter int WORD_WIDTH = m3i_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = m3i_pkg::DEF_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  m3i_pkg::m3i_in_t  matrix,
    output logic              done,
    output m3i_pkg::m3i_out_t inverse
);
    import m3i_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int DW = 3 * W + 3;

    logic                 accept;
    logic signed [W-1:0]  elem [9];
    logic                 front_valid;
    logic signed [2*W:0]  adj [9];
    logic signed [DW-1:0] det;
    logic [FIELD_W-1:0]   lane_value [9];
    m3i_lane_stat_t       lane_stat [9];
    logic [8:0]           sat_vec;

    logic                 done_reg;
    m3i_out_t             inverse_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Keep the low WORD_WIDTH bits of each element
    assign elem[0] = matrix.m00[W-1:0];
    assign elem[1] = matrix.m01[W-1:0];
    assign elem[2] = matrix.m02[W-1:0];
    assign elem[3] = matrix.m10[W-1:0];
    assign elem[4] = matrix.m11[W-1:0];
    assign elem[5] = matrix.m12[W-1:0];
    assign elem[6] = matrix.m20[W-1:0];
    assign elem[7] = matrix.m21[W-1:0];
    assign elem[8] = matrix.m22[W-1:0];

    m3i_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .elem      (elem),
        .out_valid (front_valid),
        .adj       (adj),
        .det       (det)
    );

    for (genvar g = 0; g < 9; g++) begin : g_lane
        m3i_lane #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (front_valid),
            .adj      (adj[g]),
            .det      (det),
            .value    (lane_value[g]),
            .stat     (lane_stat[g])
        );
        assign sat_vec[g] = lane_stat[g].sat;
    end

    // Merge lane flags into one status and register the result word
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= lane_stat[0].valid;
        end
    end

    always_ff @(posedge clk) begin
        inverse_reg.inv00 <= lane_value[0];
        inverse_reg.inv01 <= lane_value[1];
        inverse_reg.inv02 <= lane_value[2];
        inverse_reg.inv10 <= lane_value[3];
        inverse_reg.inv11 <= lane_value[4];
        inverse_reg.inv12 <= lane_value[5];
        inverse_reg.inv20 <= lane_value[6];
        inverse_reg.inv21 <= lane_value[7];
        inverse_reg.inv22 <= lane_value[8];
        if (lane_stat[0].singular) begin
            inverse_reg.status <= ST_SINGULAR;
        end else if (|sat_vec) begin
            inverse_reg.status <= ST_SATURATED;
        end else begin
            inverse_reg.status <= ST_OK;
        end
    end

    assign done    = done_reg;
    assign inverse = inverse_reg;

endmodule

FILE: bench/matrix3x3_inverse_core_tb.sv
// Testbench for matrix3x3_inverse_core: random and directed 3x3 matrices in Q16.16.
// Depends on m3i_pkg and the core; predicts each inverse with exact wide arithmetic.
`timescale 1ns / 1ps

module matrix3x3_inverse_core_tb;
    import m3i_pkg::*;

    localparam int WW      = DEF_WORD_WIDTH;
    localparam int FB      = DEF_FRAC_BITS;
    localparam int LATENCY = WW + 8;
    localparam int WDOG    = 2000;
    localparam int N_RAND  = 450;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    m3i_in_t  matrix;
    logic     done;
    m3i_out_t inverse;

    m3i_in_t  pending_words[$];
    m3i_out_t inverse_expected[$];
    int       error_count;
    int       accepted_count;
    int       result_count;
    int       singular_seen;
    int       saturated_seen;
    int       idle_cycles;
    int       send_idle_pct;

    matrix3x3_inverse_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .matrix  (matrix),
        .done    (done),
        .inverse (inverse)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Compute the expected inverse with exact signed arithmetic
    function automatic m3i_out_t compute_inverse(m3i_in_t w);
        logic signed [WW-1:0]  e [9];
        logic signed [129:0]   adj [9];
        logic signed [129:0]   det;
        logic signed [129:0]   num;
        logic signed [129:0]   q;
        logic signed [129:0]   maxv;
        logic signed [129:0]   minv;
        logic signed [WW-1:0]  r [9];
        logic [1:0]            st;
        m3i_out_t              o;
        e[0] = w.m00; e[1] = w.m01; e[2] = w.m02;
        e[3] = w.m10; e[4] = w.m11; e[5] = w.m12;
        e[6] = w.m20; e[7] = w.m21; e[8] = w.m22;
        for (int i = 0; i < 9; i++)
        begin
            adj[i] = 130'(e[ADJ_IDX[i][0]]) * 130'(e[ADJ_IDX[i][1]])
                   - 130'(e[ADJ_IDX[i][2]]) * 130'(e[ADJ_IDX[i][3]]);
        end
        det = 130'(e[0]) * adj[0] + 130'(e[1]) * adj[3] + 130'(e[2]) * adj[6];
        maxv = (130'sd1 <<< (WW-1)) - 1;
        minv = -(130'sd1 <<< (WW-1));
        st = ST_OK;
        for (int i = 0; i < 9; i++)
        begin
            if (det == 0)
                r[i] = '0;
            else
            begin
                num = adj[i] <<< (2*FB);
                q = num / det;   // truncates toward zero
                if (q > maxv)
                begin
                    q = maxv;
                    st = ST_SATURATED;
                end
                else if (q < minv)
                begin
                    q = minv;
                    st = ST_SATURATED;
                end
                r[i] = q[WW-1:0];
            end
        end
        if (det == 0)
            st = ST_SINGULAR;
        o.inv00 = r[0]; o.inv01 = r[1]; o.inv02 = r[2];
        o.inv10 = r[3]; o.inv11 = r[4]; o.inv12 = r[5];
        o.inv20 = r[6]; o.inv21 = r[7]; o.inv22 = r[8];
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch on result %0d: %s got %h want %h", result_count, what, got, want);
    endtask

    // Drive words at the falling edge, honoring the sender idle phase
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (pending_words.size() > 0 && !busy
                 && $urandom_range(99, 0) >= send_idle_pct)
        begin
            start  <= 1'b1;
            matrix <= pending_words[0];
        end
        else
            start <= 1'b0;
    end

    // Accept words, check results and watch for hangs at the rising edge
    always @(posedge clk)
    begin
        m3i_out_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                inverse_expected.push_back(compute_inverse(pending_words[0]));
                void'(pending_words.pop_front());
                accepted_count++;
            end
            if (done)
            begin
                if (inverse_expected.size() == 0)
                begin
                    error_count++;
                    $display("unexpected result %0d", result_count);
                end
                else
                begin
                    want = inverse_expected.pop_front();
                    if (inverse.inv00 !== want.inv00) report_mismatch("inv00", inverse.inv00, want.inv00);
                    if (inverse.inv01 !== want.inv01) report_mismatch("inv01", inverse.inv01, want.inv01);
                    if (inverse.inv02 !== want.inv02) report_mismatch("inv02", inverse.inv02, want.inv02);
                    if (inverse.inv10 !== want.inv10) report_mismatch("inv10", inverse.inv10, want.inv10);
                    if (inverse.inv11 !== want.inv11) report_mismatch("inv11", inverse.inv11, want.inv11);
                    if (inverse.inv12 !== want.inv12) report_mismatch("inv12", inverse.inv12, want.inv12);
                    if (inverse.inv20 !== want.inv20) report_mismatch("inv20", inverse.inv20, want.inv20);
                    if (inverse.inv21 !== want.inv21) report_mismatch("inv21", inverse.inv21, want.inv21);
                    if (inverse.inv22 !== want.inv22) report_mismatch("inv22", inverse.inv22, want.inv22);
                    if (inverse.status !== want.status)
                        report_mismatch("status", 32'(inverse.status), 32'(want.status));
                    if (want.status == ST_SINGULAR) singular_seen++;
                    if (want.status == ST_SATURATED) saturated_seen++;
                end
                result_count++;
            end
            // Count cycles with no traffic while work is outstanding
            if ((start && !busy) || done || (pending_words.size() == 0
                                             && inverse_expected.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG)
            begin
                $display("watchdog expired after %0d idle cycles", WDOG);
                $display("[matrix3x3_inverse_core] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 * 65536, 0)) - 4 * 65536);
            2: return 32'($signed($urandom_range(512, 0)) - 256);
            default: return ($urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff);
        endcase
    endfunction

    function automatic m3i_in_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        m3i_in_t w;
        w = '0;
        w.m00 = a; w.m11 = b; w.m22 = c;
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || inverse_expected.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        m3i_in_t w;
        int kind;
        logic [31:0] v [9];
        error_count = 0; accepted_count = 0; result_count = 0;
        singular_seen = 0; saturated_seen = 0; idle_cycles = 0;
        send_idle_pct = 0;
        rst_n = 1'b0; start = 1'b0; matrix = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, scaled, singular, extremes, saturation
        pending_words.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        pending_words.push_back(diag(32'h0002_0000, 32'hffff_0000, 32'h0000_8000));
        pending_words.push_back('0);
        pending_words.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0));
        pending_words.push_back(diag(32'h1, 32'h1, 32'h1));
        pending_words.push_back(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_words.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(diag(32'h8000_0000, 32'h7fff_ffff, 32'h1));
        pending_words.push_back({9{32'hffff_ffff}});
        pending_words.push_back({9{32'h8000_0000}});
        pending_words.push_back({9{32'h7fff_ffff}});
        w = diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        w.m01 = 32'h0003_0000; w.m12 = 32'hfffe_0000; w.m20 = 32'h0000_4000;
        pending_words.push_back(w);
        w = '0;
        w.m02 = 32'h0001_0000; w.m11 = 32'h0001_0000; w.m20 = 32'hffff_0000;
        pending_words.push_back(w);
        w = {32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
             32'h1, 32'h0, 32'hffff_ffff, 32'h8000_0000};
        pending_words.push_back(w);
        wait_drained();

        // Random phases: no idling, heavy idling, light idling
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 0 : (ph == 1) ? 67 : 19;
            for (int n = 0; n < N_RAND / 3; n++)
            begin
                kind = $urandom_range(3, 0);
                for (int i = 0; i < 9; i++)
                    v[i] = ($urandom_range(7, 0) == 0) ? rand_elem(3) : rand_elem(kind);
                // Some rows made dependent to hit singular cases
                if ($urandom_range(9, 0) == 0)
                begin
                    v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
                end
                w = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
                pending_words.push_back(w);
            end
            wait_drained();
        end
        repeat (LATENCY + 4) @(posedge clk);

        $display("sent %0d matrices, checked %0d: %0d singular, %0d saturated",
                 accepted_count, result_count, singular_seen, saturated_seen);
        $display("three sender phases: back to back, idle 67 of 100, idle 19 of 100");
        if (inverse_expected.size() > 0)
        begin
            error_count++;
            $display("%0d results never arrived", inverse_expected.size());
        end
        if (error_count == 0)
            $display("[matrix3x3_inverse_core] OK");
        else
            $display("[matrix3x3_inverse_core] ERROR");
        $finish;
    end
endmodule
